FILE: src/s20_pkg.sv
// Shared types, constants and helper functions for the Salsa20 core block.
// No dependencies; every other file in src uses this package.
`timescale 1ns / 1ps

package s20_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] matrix_t;

  localparam int WORDS = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_REGS = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_0_7  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_8_15 = 3'd5;

  // Word indexes a, b, c, d of the four column and the four row quarter-rounds.
  localparam logic [3:0] QR_IDX [8][4] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12}, '{4'd5,  4'd9,  4'd13, 4'd1},
    '{4'd10, 4'd14, 4'd2,  4'd6},  '{4'd15, 4'd3,  4'd7,  4'd11},
    '{4'd0,  4'd1,  4'd2,  4'd3},  '{4'd5,  4'd6,  4'd7,  4'd4},
    '{4'd10, 4'd11, 4'd8,  4'd9},  '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  // Left rotation used by each of the four steps of a quarter-round.
  localparam logic [4:0] ROT_AMT [4] = '{5'd7, 5'd9, 5'd13, 5'd18};

  // Key and constant registers as they leave the configuration block.
  typedef struct packed {
    logic [63:0] key_0_7;
    logic [63:0] key_8_15;
    logic [63:0] key_16_23;
    logic [63:0] key_24_31;
    logic [63:0] sigma_0_7;
    logic [63:0] sigma_8_15;
  } key_cfg_t;

  function automatic word_t rotl(word_t v, logic [4:0] n);
    return (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

  // Word index used by quarter-round q of a half round at position pos.
  function automatic logic [3:0] qr_word(int half_row, int q, int pos);
    return QR_IDX[3'(half_row * 4 + q)][2'(pos % 4)];
  endfunction

  function automatic matrix_t init_matrix(key_cfg_t k, logic [63:0] n_lo,
                                          logic [63:0] n_hi);
    matrix_t m;
    m[0]  = k.sigma_0_7[31:0];
    m[1]  = k.key_0_7[31:0];
    m[2]  = k.key_0_7[63:32];
    m[3]  = k.key_8_15[31:0];
    m[4]  = k.key_8_15[63:32];
    m[5]  = k.sigma_0_7[63:32];
    m[6]  = n_lo[31:0];
    m[7]  = n_lo[63:32];
    m[8]  = n_hi[31:0];
    m[9]  = n_hi[63:32];
    m[10] = k.sigma_8_15[31:0];
    m[11] = k.key_16_23[31:0];
    m[12] = k.key_16_23[63:32];
    m[13] = k.key_24_31[31:0];
    m[14] = k.key_24_31[63:32];
    m[15] = k.sigma_8_15[63:32];
    return m;
  endfunction

endpackage

FILE: src/s20_if.sv
// Valid/ready channel interfaces of the Salsa20 core block: input, output
// and configuration write. Depends on s20_pkg for the index width.
`timescale 1ns / 1ps

interface s20_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] nonce_low;
  logic [63:0] nonce_high;

  modport source (output valid, nonce_low, nonce_high, input ready);
  modport sink (input valid, nonce_low, nonce_high, output ready);
endinterface

interface s20_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_bytes_0_7;
  logic [63:0] block_bytes_8_15;
  logic [63:0] block_bytes_16_23;
  logic [63:0] block_bytes_24_31;
  logic [63:0] block_bytes_32_39;
  logic [63:0] block_bytes_40_47;
  logic [63:0] block_bytes_48_55;
  logic [63:0] block_bytes_56_63;

  modport source (output valid, block_bytes_0_7, block_bytes_8_15, block_bytes_16_23,
                  block_bytes_24_31, block_bytes_32_39, block_bytes_40_47,
                  block_bytes_48_55, block_bytes_56_63, input ready);
  modport sink (input valid, block_bytes_0_7, block_bytes_8_15, block_bytes_16_23,
                block_bytes_24_31, block_bytes_32_39, block_bytes_40_47,
                block_bytes_48_55, block_bytes_56_63, output ready);
endinterface

interface s20_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [s20_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/s20_cell.sv
// One pipeline cell: a single add-rotate-xor step of the four quarter-rounds
// of a column or row round. Depends on s20_pkg.
`timescale 1ns / 1ps

module s20_cell #(
  parameter int HALF_ROW = 0,
  parameter int STEP     = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  s20_pkg::matrix_t m_i,
  input  logic [63:0]      nonce_low_i,
  input  logic [63:0]      nonce_high_i,
  output logic             valid_o,
  output s20_pkg::matrix_t m_o,
  output logic [63:0]      nonce_low_o,
  output logic [63:0]      nonce_high_o
);

  localparam logic [3:0] TGT [4] = '{
    s20_pkg::qr_word(HALF_ROW, 0, STEP + 1), s20_pkg::qr_word(HALF_ROW, 1, STEP + 1),
    s20_pkg::qr_word(HALF_ROW, 2, STEP + 1), s20_pkg::qr_word(HALF_ROW, 3, STEP + 1)
  };
  localparam logic [3:0] SRC_A [4] = '{
    s20_pkg::qr_word(HALF_ROW, 0, STEP), s20_pkg::qr_word(HALF_ROW, 1, STEP),
    s20_pkg::qr_word(HALF_ROW, 2, STEP), s20_pkg::qr_word(HALF_ROW, 3, STEP)
  };
  localparam logic [3:0] SRC_B [4] = '{
    s20_pkg::qr_word(HALF_ROW, 0, STEP + 3), s20_pkg::qr_word(HALF_ROW, 1, STEP + 3),
    s20_pkg::qr_word(HALF_ROW, 2, STEP + 3), s20_pkg::qr_word(HALF_ROW, 3, STEP + 3)
  };
  localparam logic [4:0] ROT = s20_pkg::ROT_AMT[2'(STEP)];

  logic             valid_q;
  s20_pkg::matrix_t m_d, m_q;
  logic [63:0]      nonce_low_q, nonce_high_q;

  // The four quarter-rounds of one half round touch disjoint words.
  always_comb begin
    m_d = m_i;
    for (int q = 0; q < 4; q++) begin
      m_d[TGT[2'(q)]] = m_i[TGT[2'(q)]] ^
                        s20_pkg::rotl(m_i[SRC_A[2'(q)]] + m_i[SRC_B[2'(q)]], ROT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q          <= m_d;
      nonce_low_q  <= nonce_low_i;
      nonce_high_q <= nonce_high_i;
    end
  end

  assign valid_o      = valid_q;
  assign m_o          = m_q;
  assign nonce_low_o  = nonce_low_q;
  assign nonce_high_o = nonce_high_q;

endmodule

FILE: src/s20_cfg.sv
// Key and constant register file of the Salsa20 core block, written through
// the configuration channel. Depends on s20_pkg and s20_if.
`timescale 1ns / 1ps

module s20_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  s20_cfg_if.sink             cfg_i,
  output s20_pkg::key_cfg_t   key_o
);

  s20_pkg::key_cfg_t key_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_i.valid) begin
      // Writes to indexes past the last register are dropped.
      unique case (cfg_i.index)
        s20_pkg::REG_KEY_0_7:    key_q.key_0_7    <= cfg_i.data;
        s20_pkg::REG_KEY_8_15:   key_q.key_8_15   <= cfg_i.data;
        s20_pkg::REG_KEY_16_23:  key_q.key_16_23  <= cfg_i.data;
        s20_pkg::REG_KEY_24_31:  key_q.key_24_31  <= cfg_i.data;
        s20_pkg::REG_SIGMA_0_7:  key_q.sigma_0_7  <= cfg_i.data;
        s20_pkg::REG_SIGMA_8_15: key_q.sigma_8_15 <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign key_o = key_q;

endmodule

FILE: src/salsa20_core_block.sv
// Top level of the Salsa20 core block: a chain of round-step cells, the final
// feed-forward add and the output register with skid. Depends on s20_pkg,
// s20_if, s20_cfg and s20_cell.
//
// Usage:
//   The key and the 16-byte constant are written through cfg_i (index 0 to 3
//   for the key, 4 and 5 for the constant) while no word is in flight. Each
//   word on in_i carries the 16-byte nonce and counter; each word on out_o
//   carries the 64-byte Salsa20 block for it, in order of acceptance.
//   Path: the accepted word is loaded into the first cell and moves through
//   the cells in order, one cell per add-rotate-xor step of a half round;
//   from the last cell it is loaded into the output register together with
//   the feed-forward add.
//   Throughput: one word per cycle while the skid register is empty; every
//   cell hands its matrix to the next cell in each cycle the chain moves.
//   Stall: a skid register behind the output takes one more word while
//   out_o is stalled; once it is full, the whole chain holds and in_i.ready
//   is low until out_o.ready takes a word.
//   Reset clears the key and constant registers to zero and empties the
//   chain, the output register and the skid register.
`timescale 1ns / 1ps

module salsa20_core_block #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  s20_cfg_if.sink    cfg_i,
  s20_in_if.sink     in_i,
  s20_out_if.source  out_o
);

  localparam int CELLS = 8 * DOUBLE_ROUNDS;

  s20_pkg::key_cfg_t key;

  logic             vld   [CELLS+1];
  s20_pkg::matrix_t mat   [CELLS+1];
  logic [63:0]      n_lo  [CELLS+1];
  logic [63:0]      n_hi  [CELLS+1];
  logic [CELLS-1:0] vld_vec;

  logic             adv;
  logic             out_vld_q, skid_vld_q;
  s20_pkg::matrix_t out_q, skid_q, sum;
  logic             take, push;

  s20_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .key_o  (key)
  );

  assign adv        = !skid_vld_q;
  assign in_i.ready = adv;

  assign vld[0]  = in_i.valid;
  assign mat[0]  = s20_pkg::init_matrix(key, in_i.nonce_low, in_i.nonce_high);
  assign n_lo[0] = in_i.nonce_low;
  assign n_hi[0] = in_i.nonce_high;

  // Cell k runs step k % 4 of half round k / 4; even half rounds are columns.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    s20_cell #(
      .HALF_ROW ((k / 4) % 2),
      .STEP     (k % 4)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (adv),
      .valid_i      (vld[k]),
      .m_i          (mat[k]),
      .nonce_low_i  (n_lo[k]),
      .nonce_high_i (n_hi[k]),
      .valid_o      (vld[k+1]),
      .m_o          (mat[k+1]),
      .nonce_low_o  (n_lo[k+1]),
      .nonce_high_o (n_hi[k+1])
    );
    assign vld_vec[k] = vld[k+1];
  end

  // Feed-forward: user keeps key and constant fixed while words are in flight.
  always_comb begin
    s20_pkg::matrix_t init;
    init = s20_pkg::init_matrix(key, n_lo[CELLS], n_hi[CELLS]);
    for (int w = 0; w < s20_pkg::WORDS; w++) begin
      sum[4'(w)] = mat[CELLS][4'(w)] + init[4'(w)];
    end
  end

  assign take = out_vld_q && out_o.ready;
  assign push = vld[CELLS] && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !take) begin
        skid_q <= sum;
      end else begin
        out_q <= sum;
      end
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.block_bytes_0_7   = {out_q[1],  out_q[0]};
  assign out_o.block_bytes_8_15  = {out_q[3],  out_q[2]};
  assign out_o.block_bytes_16_23 = {out_q[5],  out_q[4]};
  assign out_o.block_bytes_24_31 = {out_q[7],  out_q[6]};
  assign out_o.block_bytes_32_39 = {out_q[9],  out_q[8]};
  assign out_o.block_bytes_40_47 = {out_q[11], out_q[10]};
  assign out_o.block_bytes_48_55 = {out_q[13], out_q[12]};
  assign out_o.block_bytes_56_63 = {out_q[15], out_q[14]};

  // The skid register is only ever filled behind a full output register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a word while the output register is empty");

  // While the skid register is full the chain must not move.
  a_chain_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> $stable(vld_vec))
    else $error("cell chain advanced while the skid register was full");

  // An accepted word enters the first cell.
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_vec[0])
    else $error("accepted word did not enter the first cell");

  // The skid register fills only when the output register was stalled.
  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !out_o.ready && vld[CELLS]))
    else $error("skid register filled without a stalled output");

endmodule

FILE: tb/salsa20_core_block_checker.sv
// Checker for the Salsa20 core block: shadows the key and constant registers,
// predicts each output block and compares it with what the block emits.
// Depends on s20_pkg and the channel interfaces in s20_if.
`timescale 1ns / 1ps

module salsa20_core_block_checker #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  s20_cfg_if   cfg_i,
  s20_in_if    in_i,
  s20_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef logic [7:0][63:0] block_t;

  s20_pkg::key_cfg_t key_shadow;
  block_t            expected_blocks[$];

  function automatic s20_pkg::word_t rol32(s20_pkg::word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic s20_pkg::matrix_t quarter_round(s20_pkg::matrix_t m,
                                                     int a, int b, int c, int d);
    m[4'(b)] = m[4'(b)] ^ rol32(m[4'(a)] + m[4'(d)], 7);
    m[4'(c)] = m[4'(c)] ^ rol32(m[4'(b)] + m[4'(a)], 9);
    m[4'(d)] = m[4'(d)] ^ rol32(m[4'(c)] + m[4'(b)], 13);
    m[4'(a)] = m[4'(a)] ^ rol32(m[4'(d)] + m[4'(c)], 18);
    return m;
  endfunction

  function automatic block_t salsa_block(s20_pkg::key_cfg_t k, logic [63:0] lo,
                                         logic [63:0] hi);
    s20_pkg::matrix_t start;
    s20_pkg::matrix_t x;
    block_t           blk;
    // Constant on the diagonal, key around it, nonce and counter in the middle.
    start[0]  = k.sigma_0_7[31:0];
    start[1]  = k.key_0_7[31:0];
    start[2]  = k.key_0_7[63:32];
    start[3]  = k.key_8_15[31:0];
    start[4]  = k.key_8_15[63:32];
    start[5]  = k.sigma_0_7[63:32];
    start[6]  = lo[31:0];
    start[7]  = lo[63:32];
    start[8]  = hi[31:0];
    start[9]  = hi[63:32];
    start[10] = k.sigma_8_15[31:0];
    start[11] = k.key_16_23[31:0];
    start[12] = k.key_16_23[63:32];
    start[13] = k.key_24_31[31:0];
    start[14] = k.key_24_31[63:32];
    start[15] = k.sigma_8_15[63:32];
    x = start;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      x = quarter_round(x, 0, 4, 8, 12);
      x = quarter_round(x, 5, 9, 13, 1);
      x = quarter_round(x, 10, 14, 2, 6);
      x = quarter_round(x, 15, 3, 7, 11);
      x = quarter_round(x, 0, 1, 2, 3);
      x = quarter_round(x, 5, 6, 7, 4);
      x = quarter_round(x, 10, 11, 8, 9);
      x = quarter_round(x, 15, 12, 13, 14);
    end
    for (int i = 0; i < 8; i++) begin
      blk[3'(i)] = {x[4'(2*i+1)] + start[4'(2*i+1)], x[4'(2*i)] + start[4'(2*i)]};
    end
    return blk;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    block_t actual;
    block_t want;
    if (!rst_ni) begin
      key_shadow = '0;
      expected_blocks.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          s20_pkg::REG_KEY_0_7:    key_shadow.key_0_7 = cfg_i.data;
          s20_pkg::REG_KEY_8_15:   key_shadow.key_8_15 = cfg_i.data;
          s20_pkg::REG_KEY_16_23:  key_shadow.key_16_23 = cfg_i.data;
          s20_pkg::REG_KEY_24_31:  key_shadow.key_24_31 = cfg_i.data;
          s20_pkg::REG_SIGMA_0_7:  key_shadow.sigma_0_7 = cfg_i.data;
          s20_pkg::REG_SIGMA_8_15: key_shadow.sigma_8_15 = cfg_i.data;
          default: ;  // Writes to unmapped indexes are dropped.
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        expected_blocks.push_back(salsa_block(key_shadow, in_i.nonce_low, in_i.nonce_high));
      end
      if (out_i.valid && out_i.ready) begin
        actual = {out_i.block_bytes_56_63, out_i.block_bytes_48_55, out_i.block_bytes_40_47,
                  out_i.block_bytes_32_39, out_i.block_bytes_24_31, out_i.block_bytes_16_23,
                  out_i.block_bytes_8_15, out_i.block_bytes_0_7};
        if (expected_blocks.size() == 0) begin
          fail_count_o++;
          $display("%0t: output word with nothing outstanding: %h", $time, actual);
        end else begin
          want = expected_blocks.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (actual[3'(i)] !== want[3'(i)]) begin
              fail_count_o++;
              $display("%0t: block bytes %0d..%0d expected %h actual %h",
                       $time, 8 * i, 8 * i + 7, want[3'(i)], actual[3'(i)]);
            end
          end
        end
      end
      pending_o = expected_blocks.size();
    end
  end

endmodule

FILE: tb/salsa20_core_block_tb.sv
// Top of the Salsa20 core block testbench: clock, reset, key loading, nonce
// stimulus, output back-pressure, watchdog and verdict. Depends on s20_pkg,
// s20_if, the block itself and salsa20_core_block_checker.
`timescale 1ns / 1ps

module salsa20_core_block_tb;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int LATENCY = 8 * DOUBLE_ROUNDS + 1;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TX_GAPS[PHASES] = '{0, 13, 0, 13, 13, 0};
  localparam int RX_GAPS[PHASES] = '{0, 0, 13, 13, 13, 0};

  // Indexes past the last register; the block must ignore writes to them.
  localparam logic [s20_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [s20_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIGMA_LO = 64'h3320_646E_6170_7865;
  localparam logic [63:0] SIGMA_HI = 64'h6B20_6574_7962_2D32;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   tx_gap_max;
  int   rx_gap_max;
  logic rx_hold_req;
  int   idle_cycles = 0;

  s20_cfg_if cfg_if ();
  s20_in_if  in_if ();
  s20_out_if out_if ();

  salsa20_core_block #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  salsa20_core_block_checker #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_if),
    .in_i        (in_if),
    .out_i       (out_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic cfg_write(input logic [s20_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Loads all six registers, then hits an unmapped index with junk.
  task automatic load_key(input logic [63:0] k0, k1, k2, k3, s0, s1,
                          input logic [s20_pkg::CFG_IDX_W-1:0] spare);
    cfg_write(s20_pkg::REG_KEY_0_7, k0);
    cfg_write(s20_pkg::REG_KEY_8_15, k1);
    cfg_write(s20_pkg::REG_KEY_16_23, k2);
    cfg_write(s20_pkg::REG_KEY_24_31, k3);
    cfg_write(s20_pkg::REG_SIGMA_0_7, s0);
    cfg_write(s20_pkg::REG_SIGMA_8_15, s1);
    cfg_write(spare, {$urandom, $urandom});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_nonce(input logic [63:0] lo, input logic [63:0] hi);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.nonce_low  <= lo;
    in_if.nonce_high <= hi;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stops offering words and waits until every expected block is back.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Output side: random stalls per word, plus one long hold when requested.
  initial begin
    int   stall;
    logic hold_done;
    hold_done = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
          (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] stream_nonce;
    logic [63:0] block_ctr;
    int          kind;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    in_if.valid      = 1'b0;
    in_if.nonce_low  = '0;
    in_if.nonce_high = '0;
    tx_gap_max       = 0;
    rx_gap_max       = 0;
    rx_hold_req      = 1'b0;
    rst_ni           = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers still at their reset value of zero.
    send_nonce('0, '0);
    send_nonce(ALL_ONES, ALL_ONES);
    send_nonce(ALL_ONES, '0);
    send_nonce('0, ALL_ONES);
    send_nonce(64'h8000_0000_0000_0000, 64'h1);
    drain();

    // Standard constant with a byte-ramp key, irregular timing.
    tx_gap_max = 13;
    rx_gap_max = 13;
    load_key(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
             64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918,
             SIGMA_LO, SIGMA_HI, REG_UNMAPPED_A);
    send_nonce(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_nonce(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_nonce(64'h0123_4567_89AB_CDEF, 64'h0000_0000_FFFF_FFFF);
    send_nonce(64'h0123_4567_89AB_CDEF, 64'h0000_0001_0000_0000);
    send_nonce(64'h0123_4567_89AB_CDEF, ALL_ONES);
    send_nonce(64'h0000_0001_0000_0001, 64'h8000_0000_8000_0000);
    drain();

    // Every register at its top value.
    tx_gap_max = 0;
    rx_gap_max = 0;
    load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, REG_UNMAPPED_B);
    send_nonce('0, '0);
    send_nonce(ALL_ONES, ALL_ONES);
    send_nonce({$urandom, $urandom}, {$urandom, $urandom});
    drain();

    for (int p = 0; p < PHASES; p++) begin
      tx_gap_max = TX_GAPS[p];
      rx_gap_max = RX_GAPS[p];
      case (p)
        0, 4: load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, SIGMA_LO, SIGMA_HI,
                       ($urandom_range(0, 1) != 0) ? REG_UNMAPPED_A : REG_UNMAPPED_B);
        2:    load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '0, '0, REG_UNMAPPED_A);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          ($urandom_range(0, 1) != 0) ? REG_UNMAPPED_A : REG_UNMAPPED_B);
      endcase
      // Sender runs flat out while the output is held, so the chain backs up.
      if (p == PHASES - 1) rx_hold_req = 1'b1;
      stream_nonce = {$urandom, $urandom};
      // The counter starts near a word boundary, and once near the full wrap.
      block_ctr = (p == 3) ? ALL_ONES - 64'd40 : {$urandom, 32'hFFFF_FFC0};
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          lo = stream_nonce;
          hi = block_ctr;
          block_ctr = block_ctr + 64'd1;
        end else if (kind < 8) begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end else if (kind == 8) begin
          lo = 64'h1 << $urandom_range(0, 63);
          hi = ~(64'h1 << $urandom_range(0, 63));
        end else begin
          lo = ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
          hi = ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
        end
        send_nonce(lo, hi);
      end
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
